[design/s2x_pkg.sv]
// shared constants, types and codes for the scale2x upscaler
`default_nettype none
package s2x_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 16;
    localparam int HEIGHT_LIMIT = 512;

    localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_BITS   = COL_BITS + 1;
    localparam int HALF_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int HALF_BITS  = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;

    localparam int FW_BITS      = 11;
    localparam int FH_BITS      = 10;
    localparam int ROW_BITS     = 9;
    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 1;

    localparam int S_DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((4 * PIXEL_BITS + 7) / 8) * 8;

    localparam logic [FW_BITS-1:0] FW_RESET = FW_BITS'(320);
    localparam logic [FH_BITS-1:0] FH_RESET = FH_BITS'(240);

    typedef enum logic [0:0] {
        FUNC_PIXEL = 1'b0,
        FUNC_FLUSH = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    // one classified transaction handed from front to back
    typedef struct packed {
        logic                is_drain;
        logic                emit;
        logic                b_is_e;
        logic                row_end;
        logic                frame_end;
        logic [COL_BITS-1:0] col;
        pixel_t              pixel;
    } cmd_t;

endpackage
`default_nettype wire

[design/scale2x_pixel_art_upscaler.sv]
// scale2x upscaler top level: front, command queue and back
// path: a 2x2 block passes the command queue, the line buffer read registers and the output register
// throughput: one transaction per cycle while the result side accepts, set by the dual-bank line buffer reads
// blocks of a row appear while the next source row streams in; flush ticks drain the last row
// reset clears counters, queue and valid flags; registers return to 320 x 240
// line buffer contents are not cleared by reset
`default_nettype none
module scale2x_pixel_art_upscaler (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [s2x_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [s2x_pkg::CFG_BITS-1:0]       cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [s2x_pkg::S_DATA_BITS-1:0]    s_tdata,  // pixel
    input  wire logic                               s_tuser,  // func
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [s2x_pkg::M_DATA_BITS-1:0]         m_tdata,  // top_left, top_right, bottom_left, bottom_right
    output logic                                    m_tlast,  // row_end
    output logic                                    m_tuser   // frame_end
);
    import s2x_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    s2x_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_func   (s_tuser),
        .in_pixel  (s_tdata[PIXEL_BITS-1:0]),
        .in_ready  (s_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    s2x_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    s2x_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

[design/s2x_front.sv]
// front end: accepts pixels and flush ticks, tracks position, issues commands
`default_nettype none
module s2x_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [s2x_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [s2x_pkg::CFG_BITS-1:0]        cfg_wdata,
    input  wire logic                                in_valid,
    input  wire logic                                in_func,
    input  wire logic [s2x_pkg::PIXEL_BITS-1:0]      in_pixel,
    output logic                                     in_ready,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output s2x_pkg::cmd_t                            q_cmd
);
    import s2x_pkg::*;

    localparam int CMPW = (CNT_BITS > FW_BITS) ? CNT_BITS : FW_BITS;

    logic [FW_BITS-1:0]  frame_width_reg;
    logic [FH_BITS-1:0]  frame_height_reg;
    logic [COL_BITS-1:0] column_count_reg, column_count_next;
    logic [ROW_BITS-1:0] row_count_reg, row_count_next;
    logic [COL_BITS-1:0] drain_count_reg, drain_count_next;
    logic                drain_pending_reg, drain_pending_next;
    logic                drain_top_reg, drain_top_next;

    logic [CMPW-1:0]     fw_ext, eff_w;
    logic [FH_BITS-1:0]  eff_h;
    logic [COL_BITS-1:0] cur_col;
    logic                last_col, last_row, accept, is_flush;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_flush = (in_func == FUNC_FLUSH);

    always_comb begin
        fw_ext = CMPW'(frame_width_reg);
        if (fw_ext == '0) begin
            eff_w = CMPW'(1);
        end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
            eff_w = CMPW'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext;
        end
        if (frame_height_reg == '0) begin
            eff_h = FH_BITS'(1);
        end else if (frame_height_reg > FH_BITS'(HEIGHT_LIMIT)) begin
            eff_h = FH_BITS'(HEIGHT_LIMIT);
        end else begin
            eff_h = frame_height_reg;
        end
    end

    assign cur_col  = is_flush ? drain_count_reg : column_count_reg;
    assign last_col = (CMPW'(cur_col) + CMPW'(1)) >= eff_w;
    assign last_row = (FH_BITS'(row_count_reg) + FH_BITS'(1)) >= eff_h;

    always_comb begin
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        drain_count_next   = drain_count_reg;
        drain_pending_next = drain_pending_reg;
        drain_top_next     = drain_top_reg;
        q_push             = 1'b0;
        q_cmd.is_drain     = is_flush;
        q_cmd.emit         = 1'b1;
        q_cmd.b_is_e       = drain_top_reg;
        q_cmd.row_end      = last_col;
        q_cmd.frame_end    = 1'b0;
        q_cmd.col          = cur_col;
        q_cmd.pixel        = in_pixel;
        if (!is_flush) begin
            q_cmd.emit   = (row_count_reg != '0);
            q_cmd.b_is_e = (row_count_reg == ROW_BITS'(1));
            if (accept) begin
                q_push             = 1'b1;
                drain_pending_next = 1'b0;
                if (last_col) begin
                    column_count_next = '0;
                    if (last_row) begin
                        row_count_next     = '0;
                        drain_pending_next = 1'b1;
                        drain_count_next   = '0;
                        drain_top_next     = (row_count_reg == '0);
                    end else begin
                        row_count_next = row_count_reg + ROW_BITS'(1);
                    end
                end else begin
                    column_count_next = column_count_reg + COL_BITS'(1);
                end
            end
        end else begin
            q_cmd.frame_end = last_col;
            // flush with nothing pending is taken and dropped
            if (accept && drain_pending_reg) begin
                q_push = 1'b1;
                if (last_col) begin
                    drain_pending_next = 1'b0;
                    drain_count_next   = '0;
                end else begin
                    drain_count_next = drain_count_reg + COL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= FW_RESET;
            frame_height_reg  <= FH_RESET;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            drain_count_reg   <= '0;
            drain_pending_reg <= 1'b0;
            drain_top_reg     <= 1'b0;
        end else begin
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            drain_count_reg   <= drain_count_next;
            drain_pending_reg <= drain_pending_next;
            drain_top_reg     <= drain_top_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_BITS-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

[design/s2x_queue.sv]
// small command fifo between front and back
`default_nettype none
module s2x_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire s2x_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output s2x_pkg::cmd_t      head_cmd
);
    import s2x_pkg::*;

    localparam int Q_DEPTH  = 4;
    localparam int PTR_BITS = $clog2(Q_DEPTH);
    localparam int CNT_W    = $clog2(Q_DEPTH + 1);

    cmd_t                entry_reg [Q_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push, do_pop;

    assign full       = (count_reg == CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

[design/s2x_back.sv]
// back end: line buffers, scale2x rule and output register
`default_nettype none
module s2x_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_valid,
    input  wire s2x_pkg::cmd_t                      q_head,
    output logic                                    q_pop,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [s2x_pkg::M_DATA_BITS-1:0]         m_tdata,  // top_left, top_right, bottom_left, bottom_right
    output logic                                    m_tlast,
    output logic                                    m_tuser   // frame_end
);
    import s2x_pkg::*;

    // newer row split by column parity so x and x+1 read in the same cycle
    pixel_t newer_even [HALF_DEPTH];
    pixel_t newer_odd  [HALF_DEPTH];
    pixel_t older      [MAX_WIDTH];

    pixel_t even_q_reg, odd_q_reg, older_q_reg;
    cmd_t   b_cmd_reg;
    logic   b_valid_reg;
    logic   byp_reg;
    pixel_t byp_data_reg;
    pixel_t prev_e_reg;

    logic                out_valid_reg;
    pixel_t              tl_reg, tr_reg, bl_reg, br_reg;
    logic                row_end_reg, frame_end_reg;

    logic [COL_BITS-1:0]  a_col;
    logic [HALF_BITS-1:0] a_half, a_even_addr;
    logic                 adv, a_wr, b_retire, out_load;
    pixel_t               e_b, f_raw, b_n, d_n, f_n, h_n;
    pixel_t               tl_n, tr_n, bl_n, br_n;

    assign a_col       = q_head.col;
    assign a_half      = HALF_BITS'(a_col >> 1);
    assign a_even_addr = HALF_BITS'((a_col >> 1) + COL_BITS'(a_col[0]));

    assign out_load = b_valid_reg && b_cmd_reg.emit && (!out_valid_reg || m_tready);
    assign b_retire = b_valid_reg && (!b_cmd_reg.emit || !out_valid_reg || m_tready);
    assign adv      = q_valid && (!b_valid_reg || b_retire);
    assign q_pop    = adv;
    assign a_wr     = adv && !q_head.is_drain;

    // read-first: a write and read at the same edge return the old entry
    always_ff @(posedge aclk) begin
        if (adv) begin
            even_q_reg <= newer_even[a_even_addr];
        end
        if (a_wr && !a_col[0]) begin
            newer_even[a_half] <= q_head.pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            odd_q_reg <= newer_odd[a_half];
        end
        if (a_wr && a_col[0]) begin
            newer_odd[a_half] <= q_head.pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            older_q_reg <= older[a_col];
        end
        if (b_valid_reg && !b_cmd_reg.is_drain) begin
            older[b_cmd_reg.col] <= e_b;
        end
    end

    always_comb begin
        e_b   = b_cmd_reg.col[0] ? odd_q_reg : even_q_reg;
        f_raw = b_cmd_reg.col[0] ? even_q_reg : odd_q_reg;
        b_n   = b_cmd_reg.b_is_e ? e_b : (byp_reg ? byp_data_reg : older_q_reg);
        d_n   = (b_cmd_reg.col == '0) ? e_b : prev_e_reg;
        f_n   = b_cmd_reg.row_end ? e_b : f_raw;
        h_n   = b_cmd_reg.is_drain ? e_b : b_cmd_reg.pixel;
        tl_n  = (d_n == b_n && b_n != f_n && d_n != h_n) ? d_n : e_b;
        tr_n  = (b_n == f_n && b_n != d_n && f_n != h_n) ? f_n : e_b;
        bl_n  = (d_n == h_n && d_n != b_n && h_n != f_n) ? d_n : e_b;
        br_n  = (h_n == f_n && d_n != h_n && b_n != f_n) ? f_n : e_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= 1'b1;
        end else if (b_retire) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_cmd_reg    <= q_head;
            // older write of the stage ahead may land on this same edge
            byp_reg      <= b_valid_reg && !b_cmd_reg.is_drain && (b_cmd_reg.col == a_col);
            byp_data_reg <= e_b;
        end
        if (b_retire) begin
            prev_e_reg <= e_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            tl_reg        <= tl_n;
            tr_reg        <= tr_n;
            bl_reg        <= bl_n;
            br_reg        <= br_n;
            row_end_reg   <= b_cmd_reg.row_end;
            frame_end_reg <= b_cmd_reg.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_BITS'({br_reg, bl_reg, tr_reg, tl_reg});
    assign m_tlast  = row_end_reg;
    assign m_tuser  = frame_end_reg;

endmodule
`default_nettype wire

[tb/s2x_checker.sv]
// scale2x checker: tracks the line stores, predicts every 2x2 block and compares the results
module s2x_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [s2x_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [s2x_pkg::CFG_BITS-1:0]         cfg_wdata,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [s2x_pkg::S_DATA_BITS-1:0]      s_tdata,  // pixel
    input  logic                                 s_tuser,  // func
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [s2x_pkg::M_DATA_BITS-1:0]      m_tdata,  // top_left, top_right, bottom_left, bottom_right
    input  logic                                 m_tlast,  // row_end
    input  logic                                 m_tuser,  // frame_end
    output int                                   blocks_waiting,
    output int                                   fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import s2x_pkg::*;

    typedef struct packed {
        pixel_t top_left;
        pixel_t top_right;
        pixel_t bottom_left;
        pixel_t bottom_right;
        logic   row_end;
        logic   frame_end;
    } block_t;

    pixel_t older_row [MAX_WIDTH] = '{default: '0};
    pixel_t newer_row [MAX_WIDTH] = '{default: '0};
    int unsigned col_cnt = 0;
    int unsigned row_cnt = 0;
    int unsigned drain_col = 0;
    logic drain_on = 1'b0;
    logic drain_top = 1'b0;
    logic [FW_BITS-1:0] width_reg = FW_RESET;
    logic [FH_BITS-1:0] height_reg = FH_RESET;
    block_t blocks_due [$];
    int mismatches = 0;
    int waiting = 0;

    assign blocks_waiting = waiting;
    assign fail_count     = mismatches;

    function automatic block_t scale_block(input pixel_t e, b, d, f, h, input logic rend, fend);
        block_t blk;
        blk.top_left     = (d == b && b != f && d != h) ? d : e;
        blk.top_right    = (b == f && b != d && f != h) ? f : e;
        blk.bottom_left  = (d == h && d != b && h != f) ? d : e;
        blk.bottom_right = (h == f && d != h && b != f) ? f : e;
        blk.row_end      = rend;
        blk.frame_end    = fend;
        return blk;
    endfunction

    function automatic int unsigned row_len();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned frame_rows();
        if (height_reg == '0) return 1;
        if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return height_reg;
    endfunction

    function automatic void check_field(input string name, input pixel_t want, input pixel_t got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : track
        int unsigned w, hgt, x, r;
        pixel_t e, b, d, f, p;
        logic last;
        block_t want;
        if (!aresetn) begin
            col_cnt    = 0;
            row_cnt    = 0;
            drain_col  = 0;
            drain_on   = 1'b0;
            drain_top  = 1'b0;
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            blocks_due.delete();
        end else begin
            // result side first: a block never leaves in the cycle of its own cause
            if (m_tvalid && m_tready) begin
                if (blocks_due.size() == 0) begin
                    $error("m_tdata: no block expected, got %h", m_tdata);
                    mismatches++;
                end else begin
                    want = blocks_due.pop_front();
                    check_field("top_left", want.top_left, m_tdata[0*PIXEL_BITS +: PIXEL_BITS]);
                    check_field("top_right", want.top_right, m_tdata[1*PIXEL_BITS +: PIXEL_BITS]);
                    check_field("bottom_left", want.bottom_left,
                                m_tdata[2*PIXEL_BITS +: PIXEL_BITS]);
                    check_field("bottom_right", want.bottom_right,
                                m_tdata[3*PIXEL_BITS +: PIXEL_BITS]);
                    check_field("row_end", pixel_t'(want.row_end), pixel_t'(m_tlast));
                    check_field("frame_end", pixel_t'(want.frame_end), pixel_t'(m_tuser));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_reg  = cfg_wdata[FW_BITS-1:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_wdata[FH_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                w   = row_len();
                hgt = frame_rows();
                p   = s_tdata[PIXEL_BITS-1:0];
                if (s_tuser == FUNC_PIXEL) begin
                    x    = col_cnt % MAX_WIDTH;
                    r    = row_cnt;
                    last = (x + 1 >= w);
                    // a new pixel always ends any drain still under way
                    drain_on     = 1'b0;
                    e            = newer_row[x];
                    b            = older_row[x];
                    f            = last ? e : newer_row[x + 1];
                    older_row[x] = e;
                    newer_row[x] = p;
                    d            = (x > 0) ? older_row[x - 1] : e;
                    if (r > 0) begin
                        if (r == 1) b = e;
                        blocks_due.push_back(scale_block(e, b, d, f, p, last, 1'b0));
                    end
                    if (last) begin
                        col_cnt = 0;
                        if (r + 1 >= hgt) begin
                            row_cnt   = 0;
                            drain_on  = 1'b1;
                            drain_col = 0;
                            drain_top = (r == 0);
                        end else begin
                            row_cnt = r + 1;
                        end
                    end else begin
                        col_cnt = x + 1;
                    end
                end else if (drain_on) begin
                    // last row: no row below, so H is E
                    x    = drain_col % MAX_WIDTH;
                    last = (x + 1 >= w);
                    e    = newer_row[x];
                    b    = drain_top ? e : older_row[x];
                    d    = (x > 0) ? newer_row[x - 1] : e;
                    f    = last ? e : newer_row[x + 1];
                    blocks_due.push_back(scale_block(e, b, d, f, e, last, last));
                    if (last) begin
                        drain_on  = 1'b0;
                        drain_col = 0;
                    end else begin
                        drain_col = x + 1;
                    end
                end
            end
        end
        waiting <= blocks_due.size();
    end

endmodule

[tb/tb.sv]
// testbench top for the scale2x upscaler: stimulus, result-side stalls and the verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import s2x_pkg::*;

    typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_BEAT} rx_mode_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 400;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_DATA_BITS-1:0]  s_tdata = '0;     // pixel
    logic                    s_tuser = 1'b0;   // func
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_DATA_BITS-1:0]  m_tdata;          // top_left, top_right, bottom_left, bottom_right
    logic                    m_tlast;          // row_end
    logic                    m_tuser;          // frame_end
    int                      blocks_waiting;
    int                      fail_count;

    logic        hold_req = 1'b0;
    logic        steady = 1'b0;
    logic        wild = 1'b0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned cur_w = 320;
    int unsigned cur_h = 240;
    pixel_t      palette [4];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    scale2x_pixel_art_upscaler dut (.*);

    s2x_checker checker_i (.*);

    // no transaction and no register write for too long means the block is stuck
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : receiver
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        int unsigned beat;
        rx_mode   = RX_FREE;
        mode_left = 0;
        beat      = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 150);
                end
                mode_left--;
                beat++;
                case (rx_mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
                    default:   m_tready <= (beat % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_item(input func_t func, input pixel_t p);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= S_DATA_BITS'(p);
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and wait until every block has come out and the pipeline is quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (blocks_waiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_BITS'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_size(input int unsigned w_value, input int unsigned h_value);
        write_reg(REG_FRAME_WIDTH, w_value);
        write_reg(REG_FRAME_HEIGHT, h_value);
        cur_w = (w_value == 0) ? 1 : (w_value > MAX_WIDTH) ? MAX_WIDTH : w_value;
        cur_h = (h_value == 0) ? 1 : (h_value > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h_value;
    endtask

    // one frame of pixels, optionally shrunk part way through, then flush ticks
    task automatic send_frame(input int flush_delta, input logic shrink, input logic hold);
        int unsigned total, cut, k, c0, r0;
        int          n_flush;
        total = cur_w * cur_h;
        cut   = (shrink && total > 1) ? $urandom_range(1, total - 1) : total;
        // entry 0 is always fresh so the palette never holds an unknown value
        for (int i = 0; i < 4; i++)
            palette[i] = (i > 0 && $urandom_range(0, 3) == 0) ? palette[0] : pixel_t'($urandom);
        k = 0;
        while (k < total) begin
            if (k == cut) begin
                settle();
                r0 = k / cur_w;
                c0 = k % cur_w;
                // width only shrinks here so every neighbour read was written before
                set_size($urandom_range(0, cur_w), $urandom_range(0, r0 + 3));
                total = k + ((c0 >= cur_w) ? 1 : cur_w - c0)
                          + ((r0 + 1 >= cur_h) ? 0 : (cur_h - 1 - r0) * cur_w);
            end
            send_item(FUNC_PIXEL, wild ? pixel_t'($urandom) : palette[$urandom_range(0, 3)]);
            if (hold && k == cur_w) hold_req = 1'b1;
            if ($urandom_range(0, 499) == 0) settle();
            k++;
        end
        n_flush = int'(cur_w) + flush_delta;
        if (n_flush < 0) n_flush = 0;
        repeat (n_flush) send_item(FUNC_FLUSH, pixel_t'($urandom));
        items_sent += total + ((n_flush < int'(cur_w)) ? n_flush : cur_w);
    endtask

    initial begin : stimulus
        pixel_t      grid [16];
        int unsigned w_value;
        int unsigned h_value;
        int          delta;
        grid = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                 16'h0000, 16'h5A5A, 16'h5A5A, 16'hFFFF,
                 16'hA5A5, 16'h5A5A, 16'h5A5A, 16'h0000,
                 16'hA5A5, 16'hA5A5, 16'h0000, 16'h0000};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: diagonal patterns, pixel extremes, flush with nothing pending
        set_size(4, 4);
        steady = 1'b1;
        foreach (grid[i]) send_item(FUNC_PIXEL, grid[i]);
        repeat (6) send_item(FUNC_FLUSH, 16'hFFFF);
        steady = 1'b0;
        settle();

        // partial drain, then a new frame drops the rest
        set_size(3, 2);
        send_frame(-2, 1'b0, 1'b0);
        send_frame(0, 1'b0, 1'b0);
        settle();

        // size registers changed part way through a frame
        set_size(12, 10);
        send_frame(0, 1'b1, 1'b0);
        settle();
        set_size(9, 6);
        send_frame(1, 1'b1, 1'b0);
        settle();

        // long result-side hold while pixels keep coming
        set_size(16, 8);
        send_frame(0, 1'b0, 1'b1);
        settle();

        // register extremes, saturation and zero sizes
        set_size(2047, 0);
        send_frame(0, 1'b0, 1'b0);
        settle();
        set_size(1024, 2);
        send_frame(0, 1'b0, 1'b0);
        settle();
        set_size(0, 1023);
        send_frame(0, 1'b0, 1'b0);
        settle();
        set_size(1, 512);
        send_frame(0, 1'b0, 1'b0);
        settle();
        set_size(1, 1);
        send_frame(1, 1'b0, 1'b0);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 9) == 0) begin
                w_value = $urandom_range(13, 64);
                h_value = $urandom_range(0, 3);
            end else begin
                w_value = $urandom_range(0, 12);
                h_value = $urandom_range(0, 8);
            end
            set_size(w_value, h_value);
            steady = ($urandom_range(0, 4) == 0);
            wild   = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 5))
                0:       delta = -int'($urandom_range(1, cur_w));
                1:       delta = $urandom_range(1, 3);
                default: delta = 0;
            endcase
            send_frame(delta, $urandom_range(0, 5) == 0, $urandom_range(0, 30) == 0);
        end

        settle();
        repeat (16) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
